/* rtl/rdc_pkg.sv */
// Package for the radix digit converter: field widths, radix limits and the
// shared control struct for the digit stack. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    localparam int VALUE_W  = 16;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 5;
    localparam int NIBBLE_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctrl;

    // Limit a raw register write to the supported bases.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (r < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/rdc_div_step.sv */
// Shared divide unit: four restoring division steps on one nibble of the
// dividend against the radix. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_div_step (
    input  wire logic [rdc_pkg::DIGIT_W-1:0]  i_rem,
    input  wire logic [rdc_pkg::NIBBLE_W-1:0] i_bits,
    input  wire logic [rdc_pkg::RADIX_W-1:0]  i_base,
    output logic      [rdc_pkg::DIGIT_W-1:0]  o_rem,
    output logic      [rdc_pkg::NIBBLE_W-1:0] o_quot
);
    import rdc_pkg::*;

    logic [RADIX_W-1:0]  acc;
    logic [DIGIT_W-1:0]  rem_v;
    logic [NIBBLE_W-1:0] quot_v;

    // Remainder stays below the base (at most 16), so it fits four bits
    always_comb begin
        rem_v  = i_rem;
        quot_v = '0;
        acc    = '0;
        for (int i = NIBBLE_W - 1; i >= 0; i--) begin
            acc = {rem_v, i_bits[i]};
            if (acc >= i_base) begin
                acc       = acc - i_base;
                quot_v[i] = 1'b1;
            end
            rem_v = acc[DIGIT_W-1:0];
        end
        o_rem  = rem_v;
        o_quot = quot_v;
    end

endmodule

`default_nettype wire

/* rtl/rdc_digit_stack.sv */
// Last-in first-out shift stack of digits: remainders go in least
// significant first and come out most significant first. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_digit_stack #(
    parameter int DEPTH = 16
) (
    input  wire logic                         i_clk,
    input  wire rdc_pkg::t_stack_ctrl         i_ctrl,
    input  wire logic [rdc_pkg::DIGIT_W-1:0]  i_digit,
    output logic      [rdc_pkg::DIGIT_W-1:0]  o_top
);
    import rdc_pkg::*;

    logic [DIGIT_W-1:0] r_entry [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_entry[0] <= i_digit;
            for (int i = 1; i < DEPTH; i++) begin
                r_entry[i] <= r_entry[i-1];
            end
        end else if (i_ctrl.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_entry[i] <= r_entry[i+1];
            end
        end
    end

    assign o_top = r_entry[0];

endmodule

`default_nettype wire

/* rtl/radix_digit_converter.sv */
// Radix digit converter top level: radix register, division sequencer and
// output register. Depends on rdc_pkg, rdc_div_step and rdc_digit_stack.
//
// Converts one unsigned 16-bit word to the base held in the radix register
// (2 to 16; writes outside that range clamp) and emits its digits most
// significant first, one output word per digit, with o_last_digit on the
// final one; zero gives the single digit 0. One word is converted at a time:
// o_in_stall is high from acceptance until the last digit has been loaded
// into the output register. Each digit is worked out in the shared divide
// unit, which retires four quotient bits per cycle, and pushed onto the digit
// stack; the digits are then popped from the stack into the output register
// one digit at a time, waiting while the output is stalled. At most DIGITS
// digits are kept; higher ones are dropped.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter #(
    parameter int DIGITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rdc_pkg::RADIX_W-1:0]  i_cfg_wr_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [rdc_pkg::VALUE_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [rdc_pkg::DIGIT_W-1:0]  o_digit,
    output logic                              o_last_digit
);
    import rdc_pkg::*;

    localparam int CNT_W  = $clog2(DIGITS + 1);
    localparam int STEP_W = $clog2(VALUE_W / NIBBLE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W / NIBBLE_W - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [RADIX_W-1:0]  r_radix, n_radix;
    logic [RADIX_W-1:0]  r_base, n_base;
    logic [VALUE_W-1:0]  r_x, n_x;
    logic [DIGIT_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0]  r_digit, n_digit;
    logic                r_last, n_last;

    logic [DIGIT_W-1:0]  step_rem;
    logic [NIBBLE_W-1:0] step_quot;
    logic [VALUE_W-1:0]  next_x;
    logic [DIGIT_W-1:0]  stack_top;
    t_stack_ctrl         stack_ctrl;
    logic                out_free;

    rdc_div_step u_div_step (
        .i_rem  (r_rem),
        .i_bits (r_x[VALUE_W-1 -: NIBBLE_W]),
        .i_base (r_base),
        .o_rem  (step_rem),
        .o_quot (step_quot)
    );

    rdc_digit_stack #(
        .DEPTH (DIGITS)
    ) u_digit_stack (
        .i_clk   (i_clk),
        .i_ctrl  (stack_ctrl),
        .i_digit (step_rem),
        .o_top   (stack_top)
    );

    assign next_x   = {r_x[VALUE_W-NIBBLE_W-1:0], step_quot};
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_base      = r_base;
        n_x         = r_x;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_digit     = r_digit;
        n_last      = r_last;
        stack_ctrl  = '0;

        if (i_cfg_wr_en) begin
            n_radix = clamp_radix(i_cfg_wr_data);
        end

        // drop the shown word once taken; a pop below may refill it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_value;
                    n_rem   = '0;
                    n_step  = '0;
                    n_count = '0;
                    n_base  = r_radix;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_x    = next_x;
                n_rem  = step_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    // one digit finished: push remainder, restart on the quotient
                    stack_ctrl.push = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                    n_rem           = '0;
                    n_step          = '0;
                    if (next_x == '0 || n_count == CNT_W'(DIGITS)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    stack_ctrl.pop = 1'b1;
                    n_out_valid    = 1'b1;
                    n_digit        = stack_top;
                    n_last         = (r_count == CNT_W'(1));
                    n_count        = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_x     <= n_x;
        r_rem   <= n_rem;
        r_digit <= n_digit;
        r_last  <= n_last;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_digit      = r_digit;
    assign o_last_digit = r_last;

endmodule

`default_nettype wire

/* rtl/rdc_checker.sv */
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on radix_digit_converter's ports and rdc_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cfg_wr_en,
    input wire logic [rdc_pkg::RADIX_W-1:0]  i_cfg_wr_data,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic [rdc_pkg::VALUE_W-1:0]  i_value,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [rdc_pkg::DIGIT_W-1:0]  o_digit,
    input wire logic                         o_last_digit
);
    import rdc_pkg::*;

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digit)
                                       && $stable(o_last_digit))
        else $error("output word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the handshake");

    // an accepted word keeps the input side busy while it is divided
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again straight after a word");

    // a digit that is not the last means the word is still being emitted
    a_busy_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_digit |-> o_in_stall)
        else $error("input ready while a word is only partly emitted");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

`default_nettype wire
